@@ rtl/csl_pkg.sv @@
package csl_pkg;

  typedef enum logic [4:0] {
    TK_END     = 5'd0,
    TK_INT     = 5'd1,
    TK_IDENT   = 5'd2,
    TK_RETURN  = 5'd3,
    TK_KW_INT  = 5'd4,
    TK_IF      = 5'd5,
    TK_ELSE    = 5'd6,
    TK_ADD_EQ  = 5'd7,
    TK_SUB_EQ  = 5'd8,
    TK_MUL_EQ  = 5'd9,
    TK_DIV_EQ  = 5'd10,
    TK_EQ_EQ   = 5'd11,
    TK_NOT_EQ  = 5'd12,
    TK_PLUS    = 5'd13,
    TK_MINUS   = 5'd14,
    TK_STAR    = 5'd15,
    TK_SLASH   = 5'd16,
    TK_ASSIGN  = 5'd17,
    TK_SEMI    = 5'd18,
    TK_BANG    = 5'd19,
    TK_LPAREN  = 5'd20,
    TK_RPAREN  = 5'd21,
    TK_ERROR   = 5'd22
  } kind_t;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_INT   = 4'b0010,
    MODE_IDENT = 4'b0100,
    MODE_OP    = 4'b1000
  } mode_t;

  // operator index held while waiting for a possible '='
  typedef enum logic [2:0] {
    OP_PLUS   = 3'd0,
    OP_MINUS  = 3'd1,
    OP_STAR   = 3'd2,
    OP_SLASH  = 3'd3,
    OP_ASSIGN = 3'd4,
    OP_BANG   = 3'd5
  } op_t;

  // a record holds a flushed token (any length) and a new token (length one)
  typedef struct packed {
    logic  f_valid;
    kind_t f_kind;
    logic  n_valid;
    kind_t n_kind;
  } tok_ctrl_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam int NUM_KW = 4;

  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd3, 3'd2, 3'd4};

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  // top bit set when the byte is one of the pending operators
  function automatic logic [3:0] op_lookup(logic [7:0] b);
    logic [3:0] r;
    unique case (b)
      CH_PLUS:  r = {1'b1, OP_PLUS};
      CH_MINUS: r = {1'b1, OP_MINUS};
      CH_STAR:  r = {1'b1, OP_STAR};
      CH_SLASH: r = {1'b1, OP_SLASH};
      CH_EQ:    r = {1'b1, OP_ASSIGN};
      CH_BANG:  r = {1'b1, OP_BANG};
      default:  r = 4'b0000;
    endcase
    return r;
  endfunction

  function automatic kind_t single_kind(logic [2:0] op);
    kind_t k;
    unique case (op)
      OP_PLUS:   k = TK_PLUS;
      OP_MINUS:  k = TK_MINUS;
      OP_STAR:   k = TK_STAR;
      OP_SLASH:  k = TK_SLASH;
      OP_ASSIGN: k = TK_ASSIGN;
      OP_BANG:   k = TK_BANG;
      default:   k = TK_ERROR;
    endcase
    return k;
  endfunction

  function automatic kind_t double_kind(logic [2:0] op);
    kind_t k;
    unique case (op)
      OP_PLUS:   k = TK_ADD_EQ;
      OP_MINUS:  k = TK_SUB_EQ;
      OP_STAR:   k = TK_MUL_EQ;
      OP_SLASH:  k = TK_DIV_EQ;
      OP_ASSIGN: k = TK_EQ_EQ;
      OP_BANG:   k = TK_NOT_EQ;
      default:   k = TK_ERROR;
    endcase
    return k;
  endfunction

  // keywords that still match after character idx equals b
  function automatic logic [NUM_KW-1:0] kw_keep(logic [2:0] idx, logic [7:0] b);
    logic [NUM_KW-1:0] m;
    for (int k = 0; k < NUM_KW; k++) begin
      m[k] = (idx < KW_LEN[k]) && (KW_TEXT[k][idx] == b);
    end
    return m;
  endfunction

endpackage

@@ rtl/csl_if.sv @@
interface csl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface csl_token_if #(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
);
  logic                   valid;
  logic                   ready;
  logic [4:0]             token_kind;
  logic [OFFSET_BITS-1:0] token_start;
  logic [OFFSET_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]   token_line;
  logic                   last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output token_line, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input token_line, input last_of_run,
                output ready);
endinterface

@@ rtl/csl_front.sv @@
module csl_front
  import csl_pkg::*;
#(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  csl_byte_if.sink               text_in,
  input  logic                   q_full,
  output logic                   push,
  output tok_ctrl_t              ctrl,
  output logic [LINE_BITS-1:0]   line,
  output logic [OFFSET_BITS-1:0] f_start,
  output logic [OFFSET_BITS-1:0] f_len,
  output logic [OFFSET_BITS-1:0] n_start
);

  mode_t                  mode, mode_next;
  logic [2:0]             pend_op, pend_op_next;
  logic [OFFSET_BITS-1:0] run_start, run_start_next;
  logic [OFFSET_BITS-1:0] run_len, run_len_next;
  logic [NUM_KW-1:0]      kw_flags, kw_flags_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [LINE_BITS-1:0]   line_cnt, line_cnt_next;
  logic                   err, err_next;

  logic                   acc;
  logic                   clear;
  logic [7:0]             b;
  logic [3:0]             op_hit;
  logic [NUM_KW-1:0]      keep_mask;
  logic [OFFSET_BITS-1:0] pos_adv, len_grow;
  logic [LINE_BITS-1:0]   line_adv;
  kind_t                  ident_kind;

  assign b             = text_in.text_byte;
  assign text_in.ready = !q_full;
  assign acc           = text_in.valid && !q_full;
  assign op_hit        = op_lookup(b);

  assign pos_adv  = (pos != '1) ? pos + 1'b1 : pos;
  assign line_adv = (b == CH_LF && line_cnt != '1) ? line_cnt + 1'b1 : line_cnt;
  assign len_grow = (run_len != '1) ? run_len + 1'b1 : run_len;
  assign keep_mask = (run_len < OFFSET_BITS'(8)) ? kw_keep(run_len[2:0], b) : '0;

  always_comb begin
    ident_kind = TK_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (kw_flags[k] && run_len == OFFSET_BITS'(KW_LEN[k])) begin
        ident_kind = kind_t'(5'(int'(TK_RETURN) + k));
      end
    end
  end

  always_comb begin
    mode_next      = mode;
    pend_op_next   = pend_op;
    run_start_next = run_start;
    run_len_next   = run_len;
    kw_flags_next  = kw_flags;
    pos_next       = pos;
    line_cnt_next  = line_cnt;
    err_next       = err;
    clear          = 1'b0;
    ctrl           = '{f_valid: 1'b0, f_kind: TK_END, n_valid: 1'b0, n_kind: TK_END};
    f_start        = run_start;
    f_len          = run_len;

    if (err) begin
      // only the terminating zero byte gets through after an error
      if (b == CH_NUL) begin
        ctrl.n_valid = 1'b1;
        ctrl.n_kind  = TK_END;
        clear        = 1'b1;
      end else begin
        pos_next      = pos_adv;
        line_cnt_next = line_adv;
      end
    end else if (mode == MODE_OP && b == CH_EQ) begin
      ctrl.f_valid  = 1'b1;
      ctrl.f_kind   = double_kind(pend_op);
      f_len         = OFFSET_BITS'(2);
      mode_next     = MODE_IDLE;
      pos_next      = pos_adv;
      line_cnt_next = line_adv;
    end else if (mode == MODE_INT && is_digit(b)) begin
      run_len_next  = len_grow;
      pos_next      = pos_adv;
      line_cnt_next = line_adv;
    end else if (mode == MODE_IDENT && (is_alpha(b) || is_digit(b) || b == CH_UNDER)) begin
      kw_flags_next = kw_flags & keep_mask;
      run_len_next  = len_grow;
      pos_next      = pos_adv;
      line_cnt_next = line_adv;
    end else begin
      // close whatever run is open
      unique case (mode)
        MODE_INT: begin
          ctrl.f_valid = 1'b1;
          ctrl.f_kind  = TK_INT;
        end
        MODE_IDENT: begin
          ctrl.f_valid = 1'b1;
          ctrl.f_kind  = ident_kind;
        end
        MODE_OP: begin
          ctrl.f_valid = 1'b1;
          ctrl.f_kind  = single_kind(pend_op);
          f_len        = OFFSET_BITS'(1);
        end
        default: begin
        end
      endcase
      mode_next     = MODE_IDLE;
      pos_next      = pos_adv;
      line_cnt_next = line_adv;

      if (b == CH_NUL) begin
        ctrl.n_valid = 1'b1;
        ctrl.n_kind  = TK_END;
        clear        = 1'b1;
      end else if (is_space(b)) begin
        mode_next = MODE_IDLE;
      end else if (is_digit(b)) begin
        mode_next      = MODE_INT;
        run_start_next = pos;
        run_len_next   = OFFSET_BITS'(1);
      end else if (is_alpha(b)) begin
        mode_next      = MODE_IDENT;
        run_start_next = pos;
        run_len_next   = OFFSET_BITS'(1);
        kw_flags_next  = kw_keep(3'd0, b);
      end else if (op_hit[3]) begin
        mode_next      = MODE_OP;
        pend_op_next   = op_hit[2:0];
        run_start_next = pos;
        run_len_next   = OFFSET_BITS'(1);
      end else if (b == CH_SEMI) begin
        ctrl.n_valid = 1'b1;
        ctrl.n_kind  = TK_SEMI;
      end else if (b == CH_LPAREN) begin
        ctrl.n_valid = 1'b1;
        ctrl.n_kind  = TK_LPAREN;
      end else if (b == CH_RPAREN) begin
        ctrl.n_valid = 1'b1;
        ctrl.n_kind  = TK_RPAREN;
      end else begin
        ctrl.n_valid = 1'b1;
        ctrl.n_kind  = TK_ERROR;
        err_next     = 1'b1;
      end
    end

    // end of text: back to the reset state for the next text
    if (clear) begin
      mode_next      = MODE_IDLE;
      pend_op_next   = 3'd0;
      run_start_next = '0;
      run_len_next   = '0;
      kw_flags_next  = '1;
      pos_next       = '0;
      line_cnt_next  = LINE_BITS'(1);
      err_next       = 1'b0;
    end
  end

  assign push    = acc && (ctrl.f_valid || ctrl.n_valid);
  assign line    = line_cnt;
  assign n_start = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      pend_op   <= 3'd0;
      run_start <= '0;
      run_len   <= '0;
      kw_flags  <= '1;
      pos       <= '0;
      line_cnt  <= LINE_BITS'(1);
      err       <= 1'b0;
    end else if (acc) begin
      mode      <= mode_next;
      pend_op   <= pend_op_next;
      run_start <= run_start_next;
      run_len   <= run_len_next;
      kw_flags  <= kw_flags_next;
      pos       <= pos_next;
      line_cnt  <= line_cnt_next;
      err       <= err_next;
    end
  end

endmodule

@@ rtl/csl_queue.sv @@
module csl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/csl_back.sv @@
module csl_back
  import csl_pkg::*;
#(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  tok_ctrl_t              ctrl,
  input  logic [LINE_BITS-1:0]   line,
  input  logic [OFFSET_BITS-1:0] f_start,
  input  logic [OFFSET_BITS-1:0] f_len,
  input  logic [OFFSET_BITS-1:0] n_start,
  output logic                   pop,
  csl_token_if.source            tokens
);

  logic                   o_valid;
  kind_t                  o_kind;
  logic [OFFSET_BITS-1:0] o_start, o_len;
  logic [LINE_BITS-1:0]   o_line;
  logic                   o_last;
  logic                   half;
  logic                   load, take, sel_n;

  // half: the flushed token of the head record has already gone out
  assign load  = !o_valid || tokens.ready;
  assign take  = load && !q_empty;
  assign sel_n = !ctrl.f_valid || half;
  assign pop   = take && (sel_n || !ctrl.n_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      half    <= 1'b0;
    end else begin
      if (load) begin
        o_valid <= !q_empty;
      end
      if (take) begin
        half <= !sel_n && ctrl.n_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_kind  <= sel_n ? ctrl.n_kind : ctrl.f_kind;
      o_start <= sel_n ? n_start : f_start;
      o_len   <= sel_n ? OFFSET_BITS'(1) : f_len;
      o_line  <= line;
      o_last  <= sel_n || !ctrl.n_valid;
    end
  end

  assign tokens.valid        = o_valid;
  assign tokens.token_kind   = o_kind;
  assign tokens.token_start  = o_start;
  assign tokens.token_length = o_len;
  assign tokens.token_line   = o_line;
  assign tokens.last_of_run  = o_last;

endmodule

@@ rtl/c_subset_lexer.sv @@
// channel   dir  modport              payload
// text_in   in   csl_byte_if.sink     text_byte
// tokens    out  csl_token_if.source  token_kind, token_start, token_length,
//                                     token_line, last_of_run
//
// one byte is taken per cycle while the record queue has room; bytes that
// close a run and emit a token of their own give two tokens; tokens leave
// one per cycle while tokens.ready is high, from a registered output stage
// rst is synchronous and returns to line one, offset zero
// a stalled output fills the queue, after which text_in.ready drops
module c_subset_lexer
  import csl_pkg::*;
#(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  csl_byte_if.sink    text_in,
  csl_token_if.source tokens
);

  localparam int QUEUE_DEPTH = 4;
  localparam int CTRL_W      = $bits(tok_ctrl_t);
  localparam int REC_W       = CTRL_W + LINE_BITS + 3 * OFFSET_BITS;

  logic                   push, pop, q_full, q_empty;
  tok_ctrl_t              f_ctrl, b_ctrl;
  logic [LINE_BITS-1:0]   f_line, b_line;
  logic [OFFSET_BITS-1:0] f_fstart, f_flen, f_nstart;
  logic [OFFSET_BITS-1:0] b_fstart, b_flen, b_nstart;
  logic [REC_W-1:0]       rec_in, rec_out;

  csl_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .text_in(text_in),
    .q_full (q_full),
    .push   (push),
    .ctrl   (f_ctrl),
    .line   (f_line),
    .f_start(f_fstart),
    .f_len  (f_flen),
    .n_start(f_nstart)
  );

  assign rec_in = {f_ctrl, f_line, f_fstart, f_flen, f_nstart};

  csl_queue #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(rec_in),
    .pop      (pop),
    .head     (rec_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  assign {b_ctrl, b_line, b_fstart, b_flen, b_nstart} = rec_out;

  csl_back #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .ctrl   (b_ctrl),
    .line   (b_line),
    .f_start(b_fstart),
    .f_len  (b_flen),
    .n_start(b_nstart),
    .pop    (pop),
    .tokens (tokens)
  );

endmodule
